// ===== src/bia_pkg.sv =====
`default_nettype none

package bia_pkg;

  // Field and register widths
  localparam int REQ_W     = 2;
  localparam int IDX_W     = 10;
  localparam int CFG_W     = 11;
  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  // Map organization: one 32-bit word per memory row
  localparam int WORD_W  = 32;
  localparam int WORD_SH = 5;

  // Default map size
  localparam int MAX_ENTRIES_DEF = 1024;

  // Stream widths rounded up to whole bytes
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_SET   = 2'd2,
    REQ_CHECK = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MODIFY,
    ST_RESP
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic clr;       // write one zero word of the clearing pass
    logic accept;    // input transfer this cycle
    logic scan;      // examine the current word of an alloc scan
    logic modify;    // apply free, set or check to the fetched word
    logic fail;      // stage a failed result
    logic out_load;  // move staged result into the output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic req_alloc;
    logic in_range;
    logic cnt_zero;
    logic found;
    logic scan_last;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== src/bitmap_id_allocator_top.sv =====
// Bitmap ID allocator: a map of used/free entries with lowest-free allocation.
// Input channel (in_*): one request per transfer; in_tuser carries the request
// kind (alloc, free, set, check) and in_tdata the entry index.
// Output channel (out_*): exactly one result per request, in request order;
// out_tuser is the success flag, out_tdata the allocated index and check bit.
// Configuration: cfg_we writes the managed entry count; write only while idle.
// A free, set or check in range passes through the modify and response states;
// an out-of-range index or an alloc with a zero count goes straight to response.
// Alloc scans the map one 32-bit memory word per cycle through the single read
// port of the map memory, over at most ceil(count/32) words.
// One request is in work at a time; the next is taken in the cycle after the
// result moves into the output register, so the block takes no new request
// before it has handed over the result of the last one.
// Reset: a clearing pass zeroes all ceil(MAX_ENTRIES/32) map words, one word per
// cycle, with in_tready low; the count returns to 1024.
// Stall: a result waits in the output register while out_tready is low, and a
// second finished result waits in a staging register behind it.
`default_nettype none

module bitmap_id_allocator_top
  import bia_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_W-1:0]      cfg_wdata,   // entries_in_use
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,    // [9:0] bit_index
  input  wire logic [REQ_W-1:0]      in_tuser,    // [1:0] req_type
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,   // [9:0] alloc_index, [10] bit_value
  output logic                       out_tuser    // [0] success
);

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic [IDX_W-1:0] alloc_index;
  logic             bit_value;

  bia_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bia_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_req_type     (in_tuser),
    .in_bit_index    (in_tdata[IDX_W-1:0]),
    .cmd             (cmd),
    .stat            (stat),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_success     (out_tuser),
    .out_alloc_index (alloc_index),
    .out_bit_value   (bit_value)
  );

  // Pack result fields, zero fill to whole bytes
  assign out_tdata = {(OUT_DATA_W - IDX_W - 1)'(0), bit_value, alloc_index};

endmodule

`default_nettype wire

// ===== src/bia_ctrl.sv =====
`default_nettype none

module bia_ctrl
  import bia_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          if (stat.req_alloc) begin
            if (stat.cnt_zero) begin
              cmd.fail  = 1'b1;
              state_nxt = ST_RESP;
            end else begin
              state_nxt = ST_SCAN;
            end
          end else if (stat.in_range) begin
            state_nxt = ST_MODIFY;
          end else begin
            cmd.fail  = 1'b1;
            state_nxt = ST_RESP;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.found || stat.scan_last) begin
          state_nxt = ST_RESP;
        end
      end
      ST_MODIFY: begin
        cmd.modify = 1'b1;
        state_nxt  = ST_RESP;
      end
      ST_RESP: begin
        // Hand the result over once the output register has room
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/bia_datapath.sv =====
`default_nettype none

module bia_datapath
  import bia_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  input  wire logic [REQ_W-1:0] in_req_type,
  input  wire logic [IDX_W-1:0] in_bit_index,
  input  wire dp_cmd_t          cmd,
  output dp_stat_t              stat,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic                  out_success,
  output logic [IDX_W-1:0]      out_alloc_index,
  output logic                  out_bit_value
);

  localparam int WORDS = (MAX_ENTRIES + WORD_W - 1) / WORD_W;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(WORDS - 1);

  // Bit map storage
  logic [WORD_W-1:0] mem [WORDS];
  logic [WORD_W-1:0] rdata_r;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic              wr_en;

  // Control and request registers
  logic [CFG_W-1:0] entries_r;
  logic [AW-1:0]    clr_addr_r;
  logic [AW-1:0]    scan_addr_r;
  req_t             req_r;
  logic [IDX_W-1:0] idx_r;

  // Staged and output result
  logic             res_success_r, res_success_nxt;
  logic [IDX_W-1:0] res_index_r, res_index_nxt;
  logic             res_value_r, res_value_nxt;
  logic             out_valid_r;
  logic             out_success_r;
  logic [IDX_W-1:0] out_index_r;
  logic             out_value_r;

  // Derived count and scan signals
  logic [CFG_W-1:0]   eff_cnt, cnt_m1;
  logic [AW-1:0]      last_word, idx_word;
  logic [WORD_W-1:0]  valid_mask, free_bits, bit_sel, mod_word;
  logic [WORD_SH-1:0] ffz_pos;
  logic               ffz_found;
  logic               scan_last;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= CFG_RESET;
    end else if (cfg_we) begin
      entries_r <= cfg_wdata;
    end
  end

  // Saturate the count at the map size
  always_comb begin
    eff_cnt   = (32'(entries_r) > MAX_ENTRIES) ? CFG_W'(MAX_ENTRIES) : entries_r;
    cnt_m1    = eff_cnt - CFG_W'(1);
    last_word = AW'(cnt_m1 >> WORD_SH);
    idx_word  = AW'(in_bit_index >> WORD_SH);
    scan_last = (scan_addr_r == last_word);
  end

  // Find the lowest clear bit of the fetched word below the count
  always_comb begin
    valid_mask = '1;
    if (scan_last) begin
      valid_mask = {WORD_W{1'b1}} >> (WORD_SH'(WORD_W - 1) - cnt_m1[WORD_SH-1:0]);
    end
    free_bits = ~rdata_r & valid_mask;
    ffz_found = 1'b0;
    ffz_pos   = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        ffz_found = 1'b1;
        ffz_pos   = WORD_SH'(i);
      end
    end
  end

  // Single-bit update for free and set
  always_comb begin
    bit_sel  = WORD_W'(1) << idx_r[WORD_SH-1:0];
    mod_word = (req_r == REQ_FREE) ? (rdata_r & ~bit_sel) : (rdata_r | bit_sel);
  end

  // Memory port selection
  always_comb begin
    rd_addr = scan_addr_r;
    if (cmd.accept) begin
      rd_addr = (in_req_type == REQ_ALLOC) ? '0 : idx_word;
    end else if (cmd.scan && !scan_last) begin
      rd_addr = scan_addr_r + AW'(1);
    end
    wr_en   = 1'b0;
    wr_addr = scan_addr_r;
    wr_data = rdata_r | (WORD_W'(1) << ffz_pos);
    if (cmd.clr) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r;
      wr_data = '0;
    end else if (cmd.scan && ffz_found) begin
      wr_en = 1'b1;
    end else if (cmd.modify && req_r != REQ_CHECK) begin
      wr_en   = 1'b1;
      wr_addr = AW'(idx_r >> WORD_SH);
      wr_data = mod_word;
    end
  end

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  // Clearing pass address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr) begin
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  // Request capture and scan position
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r       <= req_t'(in_req_type);
      idx_r       <= in_bit_index;
      scan_addr_r <= '0;
    end else if (cmd.scan && !ffz_found && !scan_last) begin
      scan_addr_r <= scan_addr_r + AW'(1);
    end
  end

  // Stage the result
  always_comb begin
    res_success_nxt = res_success_r;
    res_index_nxt   = res_index_r;
    res_value_nxt   = res_value_r;
    if (cmd.fail || (cmd.scan && !ffz_found && scan_last)) begin
      res_success_nxt = 1'b0;
      res_index_nxt   = '0;
      res_value_nxt   = 1'b0;
    end else if (cmd.scan && ffz_found) begin
      res_success_nxt = 1'b1;
      res_index_nxt   = IDX_W'({scan_addr_r, ffz_pos});
      res_value_nxt   = 1'b0;
    end else if (cmd.modify) begin
      res_success_nxt = 1'b1;
      res_index_nxt   = '0;
      res_value_nxt   = (req_r == REQ_CHECK) ? rdata_r[idx_r[WORD_SH-1:0]] : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    res_success_r <= res_success_nxt;
    res_index_r   <= res_index_nxt;
    res_value_r   <= res_value_nxt;
  end

  // Output register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_success_r <= res_success_r;
      out_index_r   <= res_index_r;
      out_value_r   <= res_value_r;
    end
  end

  // Status to the controller
  always_comb begin
    stat.clr_last  = (clr_addr_r == LAST_ADDR);
    stat.req_alloc = (in_req_type == REQ_ALLOC);
    stat.in_range  = ({1'b0, in_bit_index} < eff_cnt);
    stat.cnt_zero  = (eff_cnt == '0);
    stat.found     = ffz_found;
    stat.scan_last = scan_last;
    stat.out_free  = !out_valid_r || out_tready;
  end

  assign out_tvalid      = out_valid_r;
  assign out_success     = out_success_r;
  assign out_alloc_index = out_index_r;
  assign out_bit_value   = out_value_r;

endmodule

`default_nettype wire
